// ===== src/assert_macros.svh =====
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FZRF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fzrf assertion failed");

// Next-cycle implication, disabled while reset is low.
`define FZRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fzrf assertion failed");

`endif

// ===== src/fzrf_pkg.sv =====
package fzrf_pkg;

  localparam int DEF_MAX_RULES  = 32;
  localparam int DEF_MAX_INPUTS = 8;
  localparam int DEF_MAX_MFS    = 8;

  localparam int GRADE_BITS = 16;
  localparam int FRAC_BITS  = GRADE_BITS - 1;
  localparam logic [GRADE_BITS-1:0] GRADE_ONE = GRADE_BITS'(1) << FRAC_BITS;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [1:0] {
    FUNC_WR_RULE  = 2'd0,
    FUNC_WR_GRADE = 2'd1,
    FUNC_EVAL     = 2'd2,
    FUNC_NOP      = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AND_METHOD = 2'd0,
    CFG_INPUTS     = 2'd1,
    CFG_RULES      = 2'd2
  } cfg_idx_e;

  // rule connective and AND t-norm codes
  localparam logic CONN_AND = 1'b0;
  localparam logic CONN_OR  = 1'b1;
  localparam logic AND_MIN  = 1'b0;
  localparam logic AND_PROD = 1'b1;

  typedef struct packed {
    func_e                 func;
    logic [4:0]            rule_slot;
    logic [2:0]            input_slot;
    logic [2:0]            mf_slot;
    logic                  connective;
    logic [GRADE_BITS-1:0] lower_grade;
    logic [GRADE_BITS-1:0] upper_grade;
  } in_item_t;

  typedef struct packed {
    logic [4:0]            rule_number;
    logic [GRADE_BITS-1:0] lower_firing;
    logic [GRADE_BITS-1:0] upper_firing;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic first;
    logic is_or;
    logic use_prod;
  } comb_ctl_t;

endpackage

// ===== src/fzrf_ram.sv =====
module fzrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fzrf_combine.sv =====
module fzrf_combine (
  input  fzrf_pkg::comb_ctl_t                  ctl_i,
  input  logic [fzrf_pkg::GRADE_BITS-1:0]      acc_lo_i,
  input  logic [fzrf_pkg::GRADE_BITS-1:0]      acc_up_i,
  input  logic [fzrf_pkg::GRADE_BITS-1:0]      gl_i,
  input  logic [fzrf_pkg::GRADE_BITS-1:0]      gu_i,
  output logic [fzrf_pkg::GRADE_BITS-1:0]      lo_o,
  output logic [fzrf_pkg::GRADE_BITS-1:0]      up_o
);
  import fzrf_pkg::*;

  logic [2*GRADE_BITS-1:0] prod_lo;
  logic [2*GRADE_BITS-1:0] prod_up;

  assign prod_lo = acc_lo_i * gl_i;
  assign prod_up = acc_up_i * gu_i;

  always_comb begin
    if (ctl_i.first) begin
      lo_o = gl_i;
      up_o = gu_i;
    end else if (ctl_i.is_or == CONN_OR) begin
      lo_o = (gl_i > acc_lo_i) ? gl_i : acc_lo_i;
      up_o = (gu_i > acc_up_i) ? gu_i : acc_up_i;
    end else if (ctl_i.use_prod == AND_PROD) begin
      lo_o = prod_lo[FRAC_BITS +: GRADE_BITS];
      up_o = prod_up[FRAC_BITS +: GRADE_BITS];
    end else begin
      lo_o = (gl_i < acc_lo_i) ? gl_i : acc_lo_i;
      up_o = (gu_i < acc_up_i) ? gu_i : acc_up_i;
    end
  end

endmodule

// ===== src/fuzzy_rule_firing_interval_type2_unit.sv =====
// Channel   Ports                               Beat taken when
// command   start, busy, req_i                  start && !busy
// result    res_valid_o, res_o                  res_valid_o (one cycle, no stall)
// config    cfg_we_i, cfg_idx_i, cfg_data_i     cfg_we_i
//
// Grade write: direct grade-memory write, never busy. Rule write: read-modify-write of the rule row (S_RMW).
// Evaluate: busy until the last rule's result is out; each rule costs one row read
// plus one grade-memory read and one min/max/product step per input.
// Async active-low reset sets control and config to defaults; table memories are not cleared.
// Results cannot be held off; one result strobe per rule.
module fuzzy_rule_firing_interval_type2_unit #(
  parameter int MAX_RULES  = fzrf_pkg::DEF_MAX_RULES,
  parameter int MAX_INPUTS = fzrf_pkg::DEF_MAX_INPUTS,
  parameter int MAX_MFS    = fzrf_pkg::DEF_MAX_MFS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  fzrf_pkg::in_item_t                req_i,
  output logic                              res_valid_o,
  output fzrf_pkg::out_item_t               res_o,
  input  logic                              cfg_we_i,
  input  logic [fzrf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fzrf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import fzrf_pkg::*;

  localparam int RA_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int IN_W     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int MF_W     = $clog2(MAX_MFS);
  localparam int GDEPTH   = MAX_INPUTS * MAX_MFS;
  localparam int GA_W     = $clog2(GDEPTH);
  localparam int CONN_BIT = MAX_INPUTS * MF_W;
  localparam int ROW_W    = CONN_BIT + 1;
  localparam int RC_W     = $clog2(MAX_RULES + 1);
  localparam int IC_W     = $clog2(MAX_INPUTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_FIRST,
    S_ACC
  } state_e;

  function automatic logic [GRADE_BITS-1:0] sat_grade(input logic [GRADE_BITS-1:0] g);
    return (g > GRADE_ONE) ? GRADE_ONE : g;
  endfunction

  function automatic logic [GA_W-1:0] grade_addr(input logic [IN_W-1:0] i,
                                                 input logic [MF_W-1:0] mf);
    return GA_W'(int'(i) * MAX_MFS + int'(mf));
  endfunction

  state_e                state_q, state_d;
  logic                  cfg_and_q, cfg_and_d;
  logic [3:0]            cfg_inputs_q, cfg_inputs_d;
  logic [5:0]            cfg_rules_q, cfg_rules_d;
  logic [RA_W-1:0]       rule_q, rule_d;
  logic [IN_W-1:0]       in_q, in_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [GRADE_BITS-1:0] acc_lo_q, acc_lo_d, acc_up_q, acc_up_d;
  logic [RA_W-1:0]       wr_rule_q, wr_rule_d;
  logic [IN_W-1:0]       wr_in_q, wr_in_d;
  logic [MF_W-1:0]       wr_mf_q, wr_mf_d;
  logic                  wr_conn_q, wr_conn_d;
  logic                  res_valid_q, res_valid_d;
  out_item_t             res_q, res_d;

  logic [RC_W-1:0]       n_rules;
  logic [IC_W-1:0]       n_inputs;
  logic                  accept;
  logic                  rule_slot_ok, grade_slot_ok;
  logic                  last_in, last_rule;
  logic [IN_W-1:0]       in_nxt;

  logic                  rram_we, rram_re;
  logic [RA_W-1:0]       rram_raddr;
  logic [ROW_W-1:0]      rram_wdata, rram_rdata;
  logic                  gram_we, gram_re;
  logic [GA_W-1:0]       gram_waddr, gram_raddr;
  logic [2*GRADE_BITS-1:0] gram_wdata, gram_rdata;

  comb_ctl_t             comb_ctl;
  logic [GRADE_BITS-1:0] comb_lo, comb_up;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  assign rule_slot_ok  = (int'(req_i.rule_slot) < MAX_RULES) &&
                         (int'(req_i.input_slot) < MAX_INPUTS) &&
                         (int'(req_i.mf_slot) < MAX_MFS);
  assign grade_slot_ok = (int'(req_i.input_slot) < MAX_INPUTS) &&
                         (int'(req_i.mf_slot) < MAX_MFS);

  always_comb begin
    if (cfg_rules_q == '0) begin
      n_rules = RC_W'(1);
    end else if (int'(cfg_rules_q) > MAX_RULES) begin
      n_rules = RC_W'(MAX_RULES);
    end else begin
      n_rules = RC_W'(cfg_rules_q);
    end
    if (cfg_inputs_q == '0) begin
      n_inputs = IC_W'(1);
    end else if (int'(cfg_inputs_q) > MAX_INPUTS) begin
      n_inputs = IC_W'(MAX_INPUTS);
    end else begin
      n_inputs = IC_W'(cfg_inputs_q);
    end
  end

  assign last_in   = (IC_W'(in_q) + IC_W'(1)) == n_inputs;
  assign last_rule = (RC_W'(rule_q) + RC_W'(1)) == n_rules;
  assign in_nxt    = IN_W'(in_q + 1'b1);

  assign comb_ctl.first    = (in_q == '0);
  assign comb_ctl.is_or    = row_q[CONN_BIT];
  assign comb_ctl.use_prod = cfg_and_q;

  fzrf_combine u_combine (
    .ctl_i    (comb_ctl),
    .acc_lo_i (acc_lo_q),
    .acc_up_i (acc_up_q),
    .gl_i     (gram_rdata[GRADE_BITS-1:0]),
    .gu_i     (gram_rdata[2*GRADE_BITS-1:GRADE_BITS]),
    .lo_o     (comb_lo),
    .up_o     (comb_up)
  );

  // rule row being written back: old row with one field and the connective replaced
  always_comb begin
    rram_wdata = rram_rdata;
    rram_wdata[int'(wr_in_q) * MF_W +: MF_W] = wr_mf_q;
    rram_wdata[CONN_BIT] = wr_conn_q;
  end

  assign gram_waddr = grade_addr(IN_W'(req_i.input_slot), MF_W'(req_i.mf_slot));
  assign gram_wdata = {sat_grade(req_i.upper_grade), sat_grade(req_i.lower_grade)};

  always_comb begin
    state_d      = state_q;
    cfg_and_d    = cfg_and_q;
    cfg_inputs_d = cfg_inputs_q;
    cfg_rules_d  = cfg_rules_q;
    rule_d       = rule_q;
    in_d         = in_q;
    row_d        = row_q;
    acc_lo_d     = acc_lo_q;
    acc_up_d     = acc_up_q;
    wr_rule_d    = wr_rule_q;
    wr_in_d      = wr_in_q;
    wr_mf_d      = wr_mf_q;
    wr_conn_d    = wr_conn_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    rram_we      = 1'b0;
    rram_re      = 1'b0;
    rram_raddr   = RA_W'(req_i.rule_slot);
    gram_we      = 1'b0;
    gram_re      = 1'b0;
    gram_raddr   = grade_addr(in_nxt, row_q[int'(in_nxt) * MF_W +: MF_W]);

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AND_METHOD: cfg_and_d    = cfg_data_i[0];
        CFG_INPUTS:     cfg_inputs_d = cfg_data_i[3:0];
        CFG_RULES:      cfg_rules_d  = cfg_data_i[5:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.func)
            FUNC_WR_RULE: begin
              if (rule_slot_ok) begin
                rram_re   = 1'b1;
                wr_rule_d = RA_W'(req_i.rule_slot);
                wr_in_d   = IN_W'(req_i.input_slot);
                wr_mf_d   = MF_W'(req_i.mf_slot);
                wr_conn_d = req_i.connective;
                state_d   = S_RMW;
              end
            end
            FUNC_WR_GRADE: begin
              gram_we = grade_slot_ok;
            end
            FUNC_EVAL: begin
              rram_re    = 1'b1;
              rram_raddr = '0;
              rule_d     = '0;
              state_d    = S_FIRST;
            end
            default: ;
          endcase
        end
      end
      S_RMW: begin
        rram_we = 1'b1;
        state_d = S_IDLE;
      end
      S_FIRST: begin
        row_d      = rram_rdata;
        in_d       = '0;
        gram_re    = 1'b1;
        gram_raddr = grade_addr('0, rram_rdata[MF_W-1:0]);
        state_d    = S_ACC;
      end
      S_ACC: begin
        acc_lo_d = comb_lo;
        acc_up_d = comb_up;
        if (last_in) begin
          res_valid_d        = 1'b1;
          res_d.rule_number  = 5'(rule_q);
          res_d.lower_firing = comb_lo;
          res_d.upper_firing = comb_up;
          res_d.last         = last_rule;
          if (last_rule) begin
            state_d = S_IDLE;
          end else begin
            rule_d     = RA_W'(rule_q + 1'b1);
            rram_re    = 1'b1;
            rram_raddr = RA_W'(rule_q + 1'b1);
            state_d    = S_FIRST;
          end
        end else begin
          in_d    = in_nxt;
          gram_re = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  fzrf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_RULES)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (rram_we),
    .waddr_i (wr_rule_q),
    .wdata_i (rram_wdata),
    .re_i    (rram_re),
    .raddr_i (rram_raddr),
    .rdata_o (rram_rdata)
  );

  fzrf_ram #(
    .WIDTH (2 * GRADE_BITS),
    .DEPTH (GDEPTH)
  ) u_grade_ram (
    .clk_i   (clk_i),
    .we_i    (gram_we),
    .waddr_i (gram_waddr),
    .wdata_i (gram_wdata),
    .re_i    (gram_re),
    .raddr_i (gram_raddr),
    .rdata_o (gram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cfg_and_q    <= AND_MIN;
      cfg_inputs_q <= 4'd2;
      cfg_rules_q  <= 6'd1;
      rule_q       <= '0;
      in_q         <= '0;
      row_q        <= '0;
      acc_lo_q     <= '0;
      acc_up_q     <= '0;
      wr_rule_q    <= '0;
      wr_in_q      <= '0;
      wr_mf_q      <= '0;
      wr_conn_q    <= CONN_AND;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      cfg_and_q    <= cfg_and_d;
      cfg_inputs_q <= cfg_inputs_d;
      cfg_rules_q  <= cfg_rules_d;
      rule_q       <= rule_d;
      in_q         <= in_d;
      row_q        <= row_d;
      acc_lo_q     <= acc_lo_d;
      acc_up_q     <= acc_up_d;
      wr_rule_q    <= wr_rule_d;
      wr_in_q      <= wr_in_d;
      wr_mf_q      <= wr_mf_d;
      wr_conn_q    <= wr_conn_d;
      res_valid_q  <= res_valid_d;
      res_q        <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== src/fzrf_checker.sv =====
`include "assert_macros.svh"

module fzrf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input fzrf_pkg::in_item_t  req_i,
  input logic                res_valid_o,
  input fzrf_pkg::out_item_t res_o
);
  import fzrf_pkg::*;

  logic eval_beat;
  logic other_beat;

  assign eval_beat  = start && !busy && (req_i.func == FUNC_EVAL);
  assign other_beat = start && !busy && (req_i.func != FUNC_EVAL);

  `FZRF_ASSERT_NEXT(a_eval_goes_busy, clk_i, rst_ni, eval_beat, busy)
  `FZRF_ASSERT_NEXT(a_write_no_result, clk_i, rst_ni, other_beat, !res_valid_o)
  `FZRF_ASSERT_NEXT(a_result_spacing, clk_i, rst_ni, res_valid_o, !res_valid_o)
  `FZRF_ASSERT_SAME(a_more_rules_busy, clk_i, rst_ni, res_valid_o && !res_o.last, busy)

endmodule

bind fuzzy_rule_firing_interval_type2_unit fzrf_checker u_fzrf_checker (.*);
